[rtl/core/iprm_pkg.sv]
// Shared types and constants for the ICMP probe reply matcher.
// No dependencies; iprm_capture, iprm_verdict and the top level import this package.
`default_nettype none

package iprm_pkg;

  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] TYPE_UNREACH       = 8'd3;
  localparam logic [7:0] PROTO_UDP          = 8'd17;

  // Outer source address sits at packet bytes 12..15
  localparam logic [7:0] SRC_FIRST = 8'd12;
  localparam logic [7:0] SRC_LAST  = 8'd15;

  // Offsets relative to the outer and inner header lengths
  localparam logic [7:0] ICMP_HDR_LEN   = 8'd8;
  localparam logic [7:0] PROTO_OFFSET   = 8'd9;
  localparam logic [7:0] PORT_HI_OFFSET = 8'd2;
  localparam logic [7:0] PORT_LO_OFFSET = 8'd3;
  localparam logic [8:0] MIN_INNER_LEN  = 9'd20;
  localparam logic [8:0] UDP_HDR_LEN    = 9'd8;

  typedef enum logic [2:0] {
    ST_MATCHED     = 3'd0,
    ST_SHORT_HDR   = 3'd1,
    ST_OTHER_TYPE  = 3'd2,
    ST_SHORT_QUOTE = 3'd3,
    ST_NOT_UDP     = 3'd4,
    ST_SHORT_INNER = 3'd5,
    ST_OUTSIDE     = 3'd6,
    ST_DUPLICATE   = 3'd7
  } status_t;

  // Field values as they stand after the current byte has been captured
  typedef struct packed {
    logic [8:0]  len;
    logic [5:0]  outer_hlen;
    logic [5:0]  quoted_hlen;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] src;
    logic [7:0]  proto;
    logic [15:0] port;
  } capture_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic [31:0] source_addr;
    logic        reached;
    logic [7:0]  icmp_code;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/iprm_in_if.sv]
// Input channel of the probe reply matcher: packet bytes and batch starts.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface iprm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] batch_port;

  modport source (output valid, func, data_byte, last_byte, batch_port, input ready);
  modport sink   (input valid, func, data_byte, last_byte, batch_port, output ready);
endinterface

`default_nettype wire

[rtl/core/iprm_out_if.sv]
// Output channel of the probe reply matcher: one verdict per packet.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface iprm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [31:0] source_addr;
  logic        reached;
  logic [7:0]  icmp_code;

  modport source (output valid, status, slot, source_addr, reached, icmp_code, input ready);
  modport sink   (input valid, status, slot, source_addr, reached, icmp_code, output ready);
endinterface

`default_nettype wire

[rtl/core/icmp_probe_reply_matcher_top.sv]
// ICMP probe reply matcher, top level: input register, capture, verdict,
// result register. Depends on iprm_pkg, iprm_in_if, iprm_out_if, iprm_capture, iprm_verdict.
//
// Feed a received IPv4 packet one byte per item on pkt, with last_byte set on its final
// byte; a func=1 item starts a new probe batch at batch_port and drops any partial packet,
// which then gives no verdict. Each packet closed by its last byte yields exactly one verdict
// item on the verdict channel, offered from the result register once its last byte has left the
// input register. The block takes one item every cycle unless a waiting verdict stalls it:
// each byte passes through an input register, byte-position compares and field capture, and
// a result register. While a verdict waits in the result register and verdict.ready is low, the
// input register holds and pkt.ready drops once it is occupied. SLOTS sets the probe window size
// (1 to 64 ports) and the number of received marks. No clearing pass is needed after reset.
`default_nettype none

module icmp_probe_reply_matcher_top
  import iprm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  iprm_in_if.sink    pkt,
  iprm_out_if.source verdict
);

  logic        s1_valid;
  logic        s1_func;
  logic [7:0]  s1_data_byte;
  logic        s1_last_byte;
  logic [15:0] s1_batch_port;

  logic    out_valid;
  result_t out_res;

  logic     out_free;
  logic     step;
  capture_t cap;
  logic     res_valid;
  result_t  res;

  assign out_free  = !out_valid || verdict.ready;
  assign step      = s1_valid && out_free;
  assign pkt.ready = !s1_valid || out_free;

  iprm_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .func      (s1_func),
    .data_byte (s1_data_byte),
    .last_byte (s1_last_byte),
    .cap       (cap)
  );

  iprm_verdict #(
    .SLOTS (SLOTS)
  ) u_verdict (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .func       (s1_func),
    .last_byte  (s1_last_byte),
    .batch_port (s1_batch_port),
    .cap        (cap),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.ready) begin
      s1_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      s1_func       <= pkt.func;
      s1_data_byte  <= pkt.data_byte;
      s1_last_byte  <= pkt.last_byte;
      s1_batch_port <= pkt.batch_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign verdict.valid       = out_valid;
  assign verdict.status      = out_res.status;
  assign verdict.slot        = out_res.slot;
  assign verdict.source_addr = out_res.source_addr;
  assign verdict.reached     = out_res.reached;
  assign verdict.icmp_code   = out_res.icmp_code;

endmodule

`default_nettype wire

[rtl/core/iprm_capture.sv]
// Byte-position capture of header fields for the probe reply matcher.
// Depends on iprm_pkg (capture_t and offset constants).
`default_nettype none

module iprm_capture
  import iprm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       func,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output capture_t        cap
);

  logic [7:0]  byte_count, byte_count_next;
  logic [5:0]  outer_hlen, outer_hlen_next;
  logic [31:0] src_capture, src_capture_next;
  logic [7:0]  type_capture, type_capture_next;
  logic [7:0]  code_capture, code_capture_next;
  logic [5:0]  quoted_hlen, quoted_hlen_next;
  logic [7:0]  proto_capture, proto_capture_next;
  logic [15:0] port_capture, port_capture_next;

  logic [7:0] p;
  logic [7:0] inner_pos;
  logic [7:0] port_base;

  always_comb begin
    p = byte_count;

    outer_hlen_next = (p == 8'd0) ? {data_byte[3:0], 2'b00} : outer_hlen;
    type_capture_next = (p == {2'b00, outer_hlen_next}) ? data_byte : type_capture;
    code_capture_next = (p == {2'b00, outer_hlen_next} + 8'd1) ? data_byte : code_capture;
    src_capture_next = (p >= SRC_FIRST && p <= SRC_LAST) ?
                       {src_capture[23:0], data_byte} : src_capture;

    inner_pos = {2'b00, outer_hlen_next} + ICMP_HDR_LEN;
    quoted_hlen_next = (p == inner_pos) ? {data_byte[3:0], 2'b00} : quoted_hlen;
    proto_capture_next = (p == inner_pos + PROTO_OFFSET) ? data_byte : proto_capture;

    port_base = inner_pos + {2'b00, quoted_hlen_next};
    port_capture_next = port_capture;
    if (p == port_base + PORT_HI_OFFSET) begin
      port_capture_next[15:8] = data_byte;
    end
    if (p == port_base + PORT_LO_OFFSET) begin
      port_capture_next[7:0] = data_byte;
    end

    // Batch start and end of packet both restart the byte position
    if (func || last_byte) begin
      byte_count_next = 8'd0;
    end else if (byte_count == 8'hff) begin
      byte_count_next = byte_count;
    end else begin
      byte_count_next = byte_count + 8'd1;
    end
  end

  always_comb begin
    cap.len         = {1'b0, p} + 9'd1;
    cap.outer_hlen  = outer_hlen_next;
    cap.quoted_hlen = quoted_hlen_next;
    cap.icmp_type   = type_capture_next;
    cap.icmp_code   = code_capture_next;
    cap.src         = src_capture_next;
    cap.proto       = proto_capture_next;
    cap.port        = port_capture_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      outer_hlen    <= '0;
      src_capture   <= '0;
      type_capture  <= '0;
      code_capture  <= '0;
      quoted_hlen   <= '0;
      proto_capture <= '0;
      port_capture  <= '0;
    end else if (step) begin
      byte_count <= byte_count_next;
      if (!func) begin
        outer_hlen    <= outer_hlen_next;
        src_capture   <= src_capture_next;
        type_capture  <= type_capture_next;
        code_capture  <= code_capture_next;
        quoted_hlen   <= quoted_hlen_next;
        proto_capture <= proto_capture_next;
        port_capture  <= port_capture_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/iprm_verdict.sv]
// Verdict logic, probe window and received marks of the probe reply matcher.
// Depends on iprm_pkg (capture_t, result_t, status codes).
`default_nettype none

module iprm_verdict
  import iprm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        func,
  input  wire logic        last_byte,
  input  wire logic [15:0] batch_port,
  input  capture_t         cap,
  output logic             res_valid,
  output result_t          res
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [15:0]      window_start;
  logic [SLOTS-1:0] received_marks;

  logic [8:0]        hl9;
  logic [16:0]       diff;
  logic              outside;
  logic [SLOT_W-1:0] idx;
  logic              matched;

  always_comb begin
    hl9     = {3'b000, cap.outer_hlen};
    diff    = {1'b0, cap.port} - {1'b0, window_start};
    outside = diff[16] || (diff[15:0] >= 16'(SLOTS));
    idx     = diff[SLOT_W-1:0];

    res     = '0;
    matched = 1'b0;
    priority if (cap.len < hl9 + {1'b0, ICMP_HDR_LEN}) begin
      res.status = ST_SHORT_HDR;
    end else if (cap.icmp_type != TYPE_TIME_EXCEEDED && cap.icmp_type != TYPE_UNREACH) begin
      res.status = ST_OTHER_TYPE;
    end else if (cap.len < hl9 + {1'b0, ICMP_HDR_LEN} + MIN_INNER_LEN) begin
      res.status = ST_SHORT_QUOTE;
    end else if (cap.proto != PROTO_UDP) begin
      res.status = ST_NOT_UDP;
    end else if (cap.len < hl9 + {1'b0, ICMP_HDR_LEN} + {3'b000, cap.quoted_hlen}
                           + UDP_HDR_LEN) begin
      res.status = ST_SHORT_INNER;
    end else if (outside) begin
      res.status = ST_OUTSIDE;
    end else if (received_marks[idx]) begin
      res.status = ST_DUPLICATE;
    end else begin
      matched         = 1'b1;
      res.status      = ST_MATCHED;
      res.slot        = diff[5:0];
      res.source_addr = cap.src;
      res.reached     = (cap.icmp_type == TYPE_UNREACH);
      res.icmp_code   = cap.icmp_code;
    end

    res_valid = step && !func && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start   <= '0;
      received_marks <= '0;
    end else if (step && func) begin
      window_start   <= batch_port;
      received_marks <= '0;
    end else if (res_valid && matched) begin
      received_marks[idx] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[sim/tb_icmp_probe_reply_matcher_top.sv]
// Testbench for icmp_probe_reply_matcher_top: streams IPv4 reply packets and batch starts,
// predicts every verdict and checks each result item as it leaves the block.
// Depends on iprm_pkg, iprm_in_if, iprm_out_if and the matcher RTL.

module tb_icmp_probe_reply_matcher_top;
  import iprm_pkg::*;

  localparam int SLOTS       = 16;
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst;

  iprm_in_if  pkt_if ();
  iprm_out_if verdict_if ();

  icmp_probe_reply_matcher_top #(.SLOTS(SLOTS)) dut (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt_if),
    .verdict (verdict_if)
  );

  // Matcher state as predicted from the accepted items
  logic [7:0]       pr_count;
  logic [5:0]       pr_ohl;
  logic [31:0]      pr_src;
  logic [7:0]       pr_type;
  logic [7:0]       pr_code;
  logic [5:0]       pr_ihl;
  logic [7:0]       pr_proto;
  logic [15:0]      pr_port;
  logic [15:0]      pr_wstart;
  logic [SLOTS-1:0] pr_marks;

  result_t    expected_verdicts[$];
  logic [7:0] pkt_buf[$];

  int  mismatches;
  int  stuck_cycles;
  int  bytes_sent;
  int  hold_request;
  bit  in_idle;
  bit  out_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void predict_verdict(logic f, logic [7:0] b, logic lst, logic [15:0] bp);
    int p, hl, inner, ihl, len, idx;
    result_t r;
    if (f) begin
      pr_marks  = '0;
      pr_wstart = bp;
      pr_count  = '0;
      return;
    end
    p = pr_count;
    if (p == 0) pr_ohl = {b[3:0], 2'b00};
    hl = pr_ohl;
    if (p == hl) pr_type = b;
    if (p == hl + 1) pr_code = b;
    if (p >= 12 && p <= 15) pr_src = {pr_src[23:0], b};
    inner = hl + 8;
    if (p == inner) pr_ihl = {b[3:0], 2'b00};
    ihl = pr_ihl;
    if (p == inner + 9) pr_proto = b;
    if (p == inner + ihl + 2) pr_port[15:8] = b;
    if (p == inner + ihl + 3) pr_port[7:0] = b;
    if (!lst) begin
      if (pr_count != 8'd255) pr_count = pr_count + 8'd1;
      return;
    end
    pr_count = '0;
    len = p + 1;
    r = '0;
    if (len < hl + 8) begin
      r.status = ST_SHORT_HDR;
    end else if (pr_type != TYPE_TIME_EXCEEDED && pr_type != TYPE_UNREACH) begin
      r.status = ST_OTHER_TYPE;
    end else if (len < inner + 20) begin
      r.status = ST_SHORT_QUOTE;
    end else if (pr_proto != PROTO_UDP) begin
      r.status = ST_NOT_UDP;
    end else if (len < inner + ihl + 8) begin
      r.status = ST_SHORT_INNER;
    end else begin
      idx = int'(pr_port) - int'(pr_wstart);
      if (idx < 0 || idx >= SLOTS) begin
        r.status = ST_OUTSIDE;
      end else if (pr_marks[idx]) begin
        r.status = ST_DUPLICATE;
      end else begin
        pr_marks[idx]  = 1'b1;
        r.status       = ST_MATCHED;
        r.slot         = idx[5:0];
        r.source_addr  = pr_src;
        r.reached      = (pr_type == TYPE_UNREACH);
        r.icmp_code    = pr_code;
      end
    end
    expected_verdicts.push_back(r);
  endfunction

  // Offer one item, wait for its handshake, then predict. Valid stays high on exit.
  task automatic send_item(logic f, logic [7:0] b, logic lst, logic [15:0] bp);
    int gap;
    gap = pick_gap(in_idle);
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_if.valid      <= 1'b1;
    pkt_if.func       <= f;
    pkt_if.data_byte  <= b;
    pkt_if.last_byte  <= lst;
    pkt_if.batch_port <= bp;
    @(posedge clk);
    while (!pkt_if.ready) @(posedge clk);
    predict_verdict(f, b, lst, bp);
    if (!f) bytes_sent++;
  endtask

  task automatic start_batch(logic [15:0] start_port);
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), start_port);
  endtask

  // Send the first count bytes of pkt_buf; mark the final one as last if close is set
  task automatic send_bytes(int count, bit close);
    for (int i = 0; i < count; i++)
      send_item(1'b0, pkt_buf[i], close && (i == count - 1), 16'($urandom_range(0, 65535)));
  endtask

  function automatic int reply_len(int oh, int ih);
    int a, b;
    a = oh * 4 + 8 + ih * 4 + 8;
    b = oh * 4 + 8 + 20;
    return (a > b) ? a : b;
  endfunction

  function automatic void put_at(int pos, logic [7:0] val);
    if (pos < pkt_buf.size()) pkt_buf[pos] = val;
  endfunction

  // Lay out a reply over random filler; later fields win where positions overlap
  function automatic void build_reply(int oh, int ih, int len, logic [7:0] typ,
                                      logic [7:0] code, logic [7:0] proto,
                                      logic [31:0] src, logic [15:0] port);
    int h, i, j;
    pkt_buf.delete();
    if (len < 1) len = 1;
    for (int k = 0; k < len; k++) pkt_buf.push_back(8'($urandom_range(0, 255)));
    h = oh * 4;
    i = h + 8;
    j = ih * 4;
    pkt_buf[0] = {pkt_buf[0][7:4], 4'(oh)};
    put_at(12, src[31:24]);
    put_at(13, src[23:16]);
    put_at(14, src[15:8]);
    put_at(15, src[7:0]);
    put_at(h, typ);
    put_at(h + 1, code);
    put_at(i, {pkt_buf[i % len][7:4], 4'(ih)});
    put_at(i + 9, proto);
    put_at(i + j + 2, port[15:8]);
    put_at(i + j + 3, port[7:0]);
  endfunction

  task automatic send_reply(int oh, int ih, int len, logic [7:0] typ, logic [7:0] code,
                            logic [7:0] proto, logic [31:0] src, logic [15:0] port);
    build_reply(oh, ih, len, typ, code, proto, src, port);
    send_bytes(pkt_buf.size(), 1'b1);
  endtask

  function automatic logic [15:0] random_window();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'(16'hffff - $urandom_range(0, SLOTS));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] random_reply_type();
    return $urandom_range(0, 1) ? TYPE_UNREACH : TYPE_TIME_EXCEEDED;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h", field, got, want);
    mismatches++;
  endtask

  // Result checker: compare each accepted verdict item with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && verdict_if.valid && verdict_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict, status", 32'(verdict_if.status), 32'h0);
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_if.status != want.status)
          report_mismatch("status", 32'(verdict_if.status), 32'(want.status));
        if (verdict_if.slot != want.slot)
          report_mismatch("slot", 32'(verdict_if.slot), 32'(want.slot));
        if (verdict_if.source_addr != want.source_addr)
          report_mismatch("source_addr", verdict_if.source_addr, want.source_addr);
        if (verdict_if.reached != want.reached)
          report_mismatch("reached", 32'(verdict_if.reached), 32'(want.reached));
        if (verdict_if.icmp_code != want.icmp_code)
          report_mismatch("icmp_code", 32'(verdict_if.icmp_code), 32'(want.icmp_code));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    verdict_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        verdict_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        verdict_if.ready <= 1'b0;
        stall_left--;
      end else begin
        verdict_if.ready <= 1'b1;
        stall_left = pick_gap(out_idle);
      end
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (pkt_if.valid && pkt_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic test_window_matches();
    start_batch(16'd1000);
    send_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'hffff_ffff,
               16'd1000);
    send_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h0a00_0001,
               16'd1000);
    send_reply(5, 5, reply_len(5, 5), TYPE_UNREACH, 8'd3, PROTO_UDP, 32'h0,
               16'(1000 + SLOTS - 1));
    send_reply(5, 5, reply_len(5, 5), TYPE_UNREACH, 8'd3, PROTO_UDP, 32'h1, 16'(1000 + SLOTS));
    send_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'd1, PROTO_UDP, 32'h2, 16'd999);
    start_batch(16'd0);
    send_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'hff, PROTO_UDP, 32'h0102_0304,
               16'd0);
    send_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h5, 16'hffff);
    start_batch(16'hffff);
    send_reply(5, 5, reply_len(5, 5), TYPE_UNREACH, 8'h80, PROTO_UDP, 32'h8000_0000, 16'hffff);
    send_reply(5, 5, reply_len(5, 5), TYPE_UNREACH, 8'd0, PROTO_UDP, 32'h6, 16'd0);
  endtask

  task automatic test_reject_verdicts();
    start_batch(16'd33000);
    send_reply(5, 5, 1, TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h7, 16'd33000);
    send_reply(5, 5, 27, TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h7, 16'd33000);
    send_reply(5, 5, reply_len(5, 5), 8'd0, 8'd0, PROTO_UDP, 32'h7, 16'd33000);
    send_reply(5, 5, reply_len(5, 5), 8'hff, 8'd0, PROTO_UDP, 32'h7, 16'd33000);
    send_reply(5, 5, 47, TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h7, 16'd33000);
    send_reply(5, 5, reply_len(5, 5), TYPE_UNREACH, 8'd0, 8'd6, 32'h7, 16'd33000);
    send_reply(5, 15, reply_len(5, 15) - 1, TYPE_UNREACH, 8'd0, PROTO_UDP, 32'h7, 16'd33000);
  endtask

  task automatic test_header_corners();
    start_batch(16'd500);
    // zero outer header length: the type lands on byte 0 itself
    send_reply(0, 5, reply_len(0, 5), TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h9, 16'd501);
    // zero inner header length: the port bytes sit two and three bytes past the inner header byte
    send_reply(5, 0, reply_len(5, 0), TYPE_TIME_EXCEEDED, 8'd2, PROTO_UDP, 32'hc0a8_0101,
               16'd502);
    send_reply(15, 15, reply_len(15, 15), TYPE_UNREACH, 8'd13, PROTO_UDP, 32'h5a5a_a5a5,
               16'd503);
    // longer than the byte counter can hold
    send_reply(5, 5, 300, TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'hdead_beef, 16'd504);
  endtask

  task automatic test_batch_mid_packet();
    start_batch(16'd7000);
    build_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h11, 16'd7000);
    send_bytes(10, 1'b0);
    start_batch(16'd7000);
    send_reply(5, 5, reply_len(5, 5), TYPE_TIME_EXCEEDED, 8'd0, PROTO_UDP, 32'h12, 16'd7000);
  endtask

  task automatic test_backpressure();
    out_idle = 1'b0;
    in_idle  = 1'b0;
    start_batch(16'd2000);
    hold_request = HOLD_CYCLES;
    // single-byte packets produce a verdict each, so the block fills quickly
    for (int k = 0; k < 12; k++) begin
      pkt_buf.delete();
      pkt_buf.push_back(8'($urandom_range(0, 255)));
      send_bytes(1, 1'b1);
    end
    for (int k = 0; k < 3; k++)
      send_reply(5, 5, reply_len(5, 5), random_reply_type(), 8'($urandom_range(0, 255)),
                 PROTO_UDP, 32'($urandom), 16'(2000 + k));
  endtask

  task automatic test_random_traffic();
    int sel, oh, ih, len, kind;
    logic [7:0] typ, proto;
    logic [15:0] port;
    bytes_sent = 0;
    while (bytes_sent < 450) begin
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      oh  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      ih  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      len = reply_len(oh, ih);
      typ   = random_reply_type();
      proto = PROTO_UDP;
      port  = ($urandom_range(0, 99) < 85) ? 16'(pr_wstart + $urandom_range(0, SLOTS - 1))
                                           : 16'($urandom_range(0, 65535));
      if (sel < 5) begin
        start_batch(random_window());
      end else if (sel < 9) begin
        build_reply(oh, ih, len, typ, 8'($urandom_range(0, 255)), proto, 32'($urandom), port);
        send_bytes($urandom_range(1, len - 1), 1'b0);
        start_batch(random_window());
      end else begin
        if (sel < 65) begin
          if ($urandom_range(0, 19) == 0) len = $urandom_range(256, 280);
          else if ($urandom_range(0, 3) == 0) len = len + $urandom_range(1, 8);
        end else begin
          kind = $urandom_range(0, 3);
          case (kind)
            0: len = $urandom_range(1, len - 1);
            1: typ = 8'($urandom_range(0, 255));
            2: proto = 8'($urandom_range(0, 255));
            default: begin
              oh    = $urandom_range(0, 15);
              ih    = $urandom_range(0, 15);
              typ   = 8'($urandom_range(0, 255));
              proto = 8'($urandom_range(0, 255));
              len   = $urandom_range(1, 80);
            end
          endcase
        end
        send_reply(oh, ih, len, typ, 8'($urandom_range(0, 255)), proto, 32'($urandom), port);
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    stuck_cycles = 0;
    bytes_sent   = 0;
    hold_request = 0;
    in_idle      = 1'b1;
    out_idle     = 1'b1;
    pr_count  = '0;
    pr_ohl    = '0;
    pr_src    = '0;
    pr_type   = '0;
    pr_code   = '0;
    pr_ihl    = '0;
    pr_proto  = '0;
    pr_port   = '0;
    pr_wstart = '0;
    pr_marks  = '0;
    rst               <= 1'b1;
    pkt_if.valid      <= 1'b0;
    pkt_if.func       <= 1'b0;
    pkt_if.data_byte  <= 8'd0;
    pkt_if.last_byte  <= 1'b0;
    pkt_if.batch_port <= 16'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_window_matches();
    test_reject_verdicts();
    test_header_corners();
    test_batch_mid_packet();
    test_backpressure();
    test_random_traffic();

    pkt_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/iprm_pkg.sv
rtl/core/iprm_in_if.sv
rtl/core/iprm_out_if.sv
rtl/core/iprm_capture.sv
rtl/core/iprm_verdict.sv
rtl/core/icmp_probe_reply_matcher_top.sv
sim/tb_icmp_probe_reply_matcher_top.sv
